@@ rtl/core/bw_pkg.sv @@
`default_nettype none
package bw_pkg;

	localparam int unsigned WEIGHT_BITS = 32;
	// one extra quotient bit so that -2^31 is reachable before clamping
	localparam int unsigned QUOT_BITS = WEIGHT_BITS + 1;
	// divider: input stage, one stage per quotient bit, output stage
	localparam int unsigned DIV_LAT = QUOT_BITS + 2;

	localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
	localparam logic [QUOT_BITS-1:0] NEG_LIM =
		{{(QUOT_BITS-WEIGHT_BITS){1'b0}}, 1'b1, {(WEIGHT_BITS-1){1'b0}}};
	localparam logic [QUOT_BITS-1:0] POS_LIM = NEG_LIM - QUOT_BITS'(1);

	typedef struct packed {
		logic full;
		logic empty;
	} bw_qstat_t;

endpackage
`default_nettype wire

@@ rtl/core/bw_front.sv @@
`default_nettype none
module bw_front import bw_pkg::*; #(
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic [COORD_BITS-1:0]   v0_x,
	input  wire logic [COORD_BITS-1:0]   v0_y,
	input  wire logic [COORD_BITS-1:0]   v1_x,
	input  wire logic [COORD_BITS-1:0]   v1_y,
	input  wire logic [COORD_BITS-1:0]   v2_x,
	input  wire logic [COORD_BITS-1:0]   v2_y,
	input  wire logic [COORD_BITS-1:0]   pix_x,
	input  wire logic [COORD_BITS-1:0]   pix_y,
	output logic                         out_valid,
	output logic                         deg,
	output logic [2*COORD_BITS+2:0]      den_mag,
	output logic                         neg0,
	output logic                         neg1,
	output logic                         neg2,
	output logic [2*COORD_BITS+4:0]      mag0,
	output logic [2*COORD_BITS+4:0]      mag1,
	output logic [2*COORD_BITS+4:0]      mag2
);

	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned PW = 2 * DW;
	localparam int unsigned UW = PW + 1;
	localparam int unsigned NW = UW + 2;

	logic vld_s1, vld_s2, vld_s3;
	logic signed [DW-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [PW-1:0] p_aybz_s2, p_azby_s2, p_azbx_s2, p_axbz_s2, p_axby_s2, p_aybx_s2;
	logic signed [UW-1:0] ux_s3, uy_s3, uz_s3;
	logic signed [UW-1:0] ux_d, uy_d, uz_d;
	logic signed [NW-1:0] n0, n1, n2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= signed'({1'b0, v1_x}) - signed'({1'b0, v0_x});
			ay_s1 <= signed'({1'b0, v2_x}) - signed'({1'b0, v0_x});
			az_s1 <= signed'({1'b0, v0_x}) - signed'({1'b0, pix_x});
			bx_s1 <= signed'({1'b0, v1_y}) - signed'({1'b0, v0_y});
			by_s1 <= signed'({1'b0, v2_y}) - signed'({1'b0, v0_y});
			bz_s1 <= signed'({1'b0, v0_y}) - signed'({1'b0, pix_y});

			p_aybz_s2 <= PW'(ay_s1) * PW'(bz_s1);
			p_azby_s2 <= PW'(az_s1) * PW'(by_s1);
			p_azbx_s2 <= PW'(az_s1) * PW'(bx_s1);
			p_axbz_s2 <= PW'(ax_s1) * PW'(bz_s1);
			p_axby_s2 <= PW'(ax_s1) * PW'(by_s1);
			p_aybx_s2 <= PW'(ay_s1) * PW'(bx_s1);

			ux_s3 <= ux_d;
			uy_s3 <= uy_d;
			uz_s3 <= uz_d;
		end
	end

	assign ux_d = UW'(p_aybz_s2) - UW'(p_azby_s2);
	assign uy_d = UW'(p_azbx_s2) - UW'(p_axbz_s2);
	assign uz_d = UW'(p_axby_s2) - UW'(p_aybx_s2);

	assign n1 = NW'(ux_s3);
	assign n2 = NW'(uy_s3);
	assign n0 = NW'(uz_s3) - n1 - n2;

	assign out_valid = vld_s3;
	assign deg       = (uz_s3 == '0);
	assign den_mag   = uz_s3[UW-1] ? UW'(-uz_s3) : UW'(uz_s3);
	assign neg0      = n0[NW-1] ^ uz_s3[UW-1];
	assign neg1      = n1[NW-1] ^ uz_s3[UW-1];
	assign neg2      = n2[NW-1] ^ uz_s3[UW-1];
	assign mag0      = n0[NW-1] ? NW'(-n0) : NW'(n0);
	assign mag1      = n1[NW-1] ? NW'(-n1) : NW'(n1);
	assign mag2      = n2[NW-1] ? NW'(-n2) : NW'(n2);

endmodule
`default_nettype wire

@@ rtl/core/bw_queue.sv @@
`default_nettype none
module bw_queue import bw_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output bw_qstat_t             stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (pop)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	assign rdata      = mem_q[rptr_q];
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule
`default_nettype wire

@@ rtl/core/bw_div.sv @@
`default_nettype none
module bw_div import bw_pkg::*; #(
	parameter int unsigned NUM_W     = 29,
	parameter int unsigned DEN_W     = 27,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic                   neg,
	input  wire logic [NUM_W-1:0]       num_mag,
	input  wire logic [DEN_W-1:0]       den_mag,
	output logic      [WEIGHT_BITS-1:0] weight
);

	localparam int unsigned AW  = NUM_W + FRAC_BITS;
	localparam int unsigned DSW = DEN_W + QUOT_BITS;
	localparam int unsigned RW  = ((AW > DSW) ? AW : DSW) + 1;

	logic [RW-1:0]        rem_s [QUOT_BITS+1];
	logic [DEN_W-1:0]     den_s [QUOT_BITS+1];
	logic [QUOT_BITS-1:0] quo_s [QUOT_BITS+1];
	logic                 neg_s [QUOT_BITS+1];
	logic                 ovf_s [QUOT_BITS+1];

	logic [RW-1:0]          dividend, den_top;
	logic [QUOT_BITS-1:0]   q;
	logic                   sat;
	logic [WEIGHT_BITS-1:0] res;

	assign dividend = RW'({num_mag, {FRAC_BITS{1'b0}}});
	assign den_top  = RW'(den_mag) << QUOT_BITS;

	// quotient must fit QUOT_BITS for the bit stages below to be exact
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= dividend;
			den_s[0] <= den_mag;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= (dividend >= den_top);
		end
	end

	for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_bit
		localparam int unsigned SH = QUOT_BITS - k;
		logic [RW:0] trial;

		assign trial = {1'b0, rem_s[k-1]} - ((RW+1)'(den_s[k-1]) << SH);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= trial[RW] ? rem_s[k-1] : trial[RW-1:0];
				quo_s[k] <= trial[RW] ? quo_s[k-1]
				                      : (quo_s[k-1] | (QUOT_BITS'(1) << SH));
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign q = quo_s[QUOT_BITS];

	always_comb begin
		if (neg_s[QUOT_BITS]) begin
			sat = ovf_s[QUOT_BITS] || (q > NEG_LIM);
			res = sat ? WEIGHT_MIN : WEIGHT_BITS'(QUOT_BITS'(0) - q);
		end else begin
			sat = ovf_s[QUOT_BITS] || (q > POS_LIM);
			res = sat ? WEIGHT_MAX : q[WEIGHT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			weight <= res;
	end

endmodule
`default_nettype wire

@@ rtl/core/barycentric_weights_top.sv @@
`default_nettype none
// Barycentric weights of a pixel against a 2D triangle. Takes one item per
// clock and gives one result per item, in order; throughput is one item per
// cycle while out_ready stays high. The path runs through three front
// stages (edge differences, six 13x13-class products, cross product), the
// four-entry queue, then the divider lanes,
// which are restoring dividers retiring one quotient bit per stage. Weights
// are signed fixed point with FRAC_BITS fraction bits, truncated toward zero
// and clamped to 32 bits. When the cross product z term is zero, degenerate
// is set and the weights read -1.0, 1.0, 1.0.
module barycentric_weights_top import bw_pkg::*; #(
	parameter int unsigned COORD_BITS = 12,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [COORD_BITS-1:0]  v0_x,
	input  wire logic [COORD_BITS-1:0]  v0_y,
	input  wire logic [COORD_BITS-1:0]  v1_x,
	input  wire logic [COORD_BITS-1:0]  v1_y,
	input  wire logic [COORD_BITS-1:0]  v2_x,
	input  wire logic [COORD_BITS-1:0]  v2_y,
	input  wire logic [COORD_BITS-1:0]  pix_x,
	input  wire logic [COORD_BITS-1:0]  pix_y,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [WEIGHT_BITS-1:0] weight0,
	output logic signed [WEIGHT_BITS-1:0] weight1,
	output logic signed [WEIGHT_BITS-1:0] weight2,
	output logic                        degenerate
);

	localparam int unsigned UW = 2 * COORD_BITS + 3;
	localparam int unsigned NW = UW + 2;
	localparam int unsigned QW = 1 + UW + 3 * (1 + NW);
	localparam int unsigned Q_DEPTH = 4;
	localparam logic [WEIGHT_BITS-1:0] FIX_ONE = WEIGHT_BITS'(1) << FRAC_BITS;
	localparam logic [WEIGHT_BITS-1:0] FIX_NEG_ONE = WEIGHT_BITS'(0) - FIX_ONE;

	logic          f_en, f_valid, f_deg, f_neg0, f_neg1, f_neg2;
	logic [UW-1:0] f_den;
	logic [NW-1:0] f_mag0, f_mag1, f_mag2;

	logic          q_deg, q_neg0, q_neg1, q_neg2;
	logic [UW-1:0] q_den;
	logic [NW-1:0] q_mag0, q_mag1, q_mag2;
	logic [QW-1:0] q_wdata, q_rdata;
	bw_qstat_t     qstat;

	logic b_en, b_pop;
	logic vld_s [DIV_LAT];
	logic deg_s [DIV_LAT];
	logic [WEIGHT_BITS-1:0] d_w0, d_w1, d_w2;

	assign f_en     = !qstat.full;
	assign in_ready = f_en;

	bw_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (f_en),
		.in_valid (in_valid),
		.v0_x     (v0_x),
		.v0_y     (v0_y),
		.v1_x     (v1_x),
		.v1_y     (v1_y),
		.v2_x     (v2_x),
		.v2_y     (v2_y),
		.pix_x    (pix_x),
		.pix_y    (pix_y),
		.out_valid(f_valid),
		.deg      (f_deg),
		.den_mag  (f_den),
		.neg0     (f_neg0),
		.neg1     (f_neg1),
		.neg2     (f_neg2),
		.mag0     (f_mag0),
		.mag1     (f_mag1),
		.mag2     (f_mag2)
	);

	assign q_wdata = {f_deg, f_den, f_neg0, f_mag0, f_neg1, f_mag1, f_neg2, f_mag2};
	assign {q_deg, q_den, q_neg0, q_mag0, q_neg1, q_mag1, q_neg2, q_mag2} = q_rdata;

	bw_queue #(
		.WIDTH(QW),
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_en && f_valid),
		.wdata (q_wdata),
		.pop   (b_pop),
		.rdata (q_rdata),
		.stat  (qstat)
	);

	assign b_en  = !vld_s[DIV_LAT-1] || out_ready;
	assign b_pop = b_en && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++)
				vld_s[i] <= 1'b0;
		end else if (b_en) begin
			vld_s[0] <= !qstat.empty;
			for (int i = 1; i < DIV_LAT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (b_en) begin
			deg_s[0] <= q_deg;
			for (int i = 1; i < DIV_LAT; i++)
				deg_s[i] <= deg_s[i-1];
		end
	end

	bw_div #(.NUM_W(NW), .DEN_W(UW), .FRAC_BITS(FRAC_BITS)) u_div0 (
		.clk(clk), .en(b_en), .neg(q_neg0), .num_mag(q_mag0), .den_mag(q_den),
		.weight(d_w0)
	);

	bw_div #(.NUM_W(NW), .DEN_W(UW), .FRAC_BITS(FRAC_BITS)) u_div1 (
		.clk(clk), .en(b_en), .neg(q_neg1), .num_mag(q_mag1), .den_mag(q_den),
		.weight(d_w1)
	);

	bw_div #(.NUM_W(NW), .DEN_W(UW), .FRAC_BITS(FRAC_BITS)) u_div2 (
		.clk(clk), .en(b_en), .neg(q_neg2), .num_mag(q_mag2), .den_mag(q_den),
		.weight(d_w2)
	);

	assign out_valid  = vld_s[DIV_LAT-1];
	assign degenerate = deg_s[DIV_LAT-1];
	assign weight0    = degenerate ? FIX_NEG_ONE : d_w0;
	assign weight1    = degenerate ? FIX_ONE : d_w1;
	assign weight2    = degenerate ? FIX_ONE : d_w2;

endmodule
`default_nettype wire

@@ tb/bw_weight_checker.sv @@
`default_nettype none
module bw_weight_checker import bw_pkg::*; #(
	parameter int unsigned COORD_BITS = 12,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [COORD_BITS-1:0]        v0_x,
	input  wire logic [COORD_BITS-1:0]        v0_y,
	input  wire logic [COORD_BITS-1:0]        v1_x,
	input  wire logic [COORD_BITS-1:0]        v1_y,
	input  wire logic [COORD_BITS-1:0]        v2_x,
	input  wire logic [COORD_BITS-1:0]        v2_y,
	input  wire logic [COORD_BITS-1:0]        pix_x,
	input  wire logic [COORD_BITS-1:0]        pix_y,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic signed [WEIGHT_BITS-1:0] weight0,
	input  wire logic signed [WEIGHT_BITS-1:0] weight1,
	input  wire logic signed [WEIGHT_BITS-1:0] weight2,
	input  wire logic                         degenerate,
	output int unsigned                       pend_cnt,
	output int unsigned                       fail_cnt
);

	typedef struct {
		logic signed [WEIGHT_BITS-1:0] w0;
		logic signed [WEIGHT_BITS-1:0] w1;
		logic signed [WEIGHT_BITS-1:0] w2;
		logic                          degen;
	} bw_weights_t;

	localparam longint FIX_ONE = longint'(1) << FRAC_BITS;

	bw_weights_t pending_weights[$];
	bw_weights_t want;

	initial begin
		pend_cnt = 0;
		fail_cnt = 0;
	end

	// exact quotient, truncated toward zero, clamped to 32 bits
	function automatic longint fixed_quotient(input longint num, input longint den);
		longint q;
		q = (num * FIX_ONE) / den;
		if (q > longint'(32'sh7fffffff))
			q = longint'(32'sh7fffffff);
		if (q < -longint'(32'sh7fffffff) - 1)
			q = -longint'(32'sh7fffffff) - 1;
		return q;
	endfunction

	function automatic bw_weights_t predict_weights(
		input logic [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2, px, py
	);
		longint ax, ay, az, bx, by, bz, ux, uy, uz;
		bw_weights_t r;
		ax = longint'(x1) - longint'(x0);
		ay = longint'(x2) - longint'(x0);
		az = longint'(x0) - longint'(px);
		bx = longint'(y1) - longint'(y0);
		by = longint'(y2) - longint'(y0);
		bz = longint'(y0) - longint'(py);
		ux = ay * bz - az * by;
		uy = az * bx - ax * bz;
		uz = ax * by - ay * bx;
		if (uz == 0) begin
			r.w0    = WEIGHT_BITS'(-FIX_ONE);
			r.w1    = WEIGHT_BITS'(FIX_ONE);
			r.w2    = WEIGHT_BITS'(FIX_ONE);
			r.degen = 1'b1;
		end else begin
			r.w0    = WEIGHT_BITS'(fixed_quotient(uz - ux - uy, uz));
			r.w1    = WEIGHT_BITS'(fixed_quotient(ux, uz));
			r.w2    = WEIGHT_BITS'(fixed_quotient(uy, uz));
			r.degen = 1'b0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_weights.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pending_weights.size() == 0) begin
					$error("result item with no item outstanding");
					fail_cnt++;
				end else begin
					want = pending_weights.pop_front();
					check_field("weight0", longint'(want.w0), longint'(weight0));
					check_field("weight1", longint'(want.w1), longint'(weight1));
					check_field("weight2", longint'(want.w2), longint'(weight2));
					check_field("degenerate", longint'(want.degen), longint'(degenerate));
				end
			end
			if (in_valid && in_ready)
				pending_weights.push_back(predict_weights(v0_x, v0_y, v1_x, v1_y,
					v2_x, v2_y, pix_x, pix_y));
		end
		pend_cnt = pending_weights.size();
	end

endmodule
`default_nettype wire

@@ tb/tb_barycentric_weights_top.sv @@
`default_nettype none
module tb_barycentric_weights_top;
	import bw_pkg::*;

	localparam int unsigned CB   = 12;
	localparam int unsigned FB   = 16;
	localparam int unsigned CMAX = (1 << CB) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CB-1:0] v0_x = '0, v0_y = '0, v1_x = '0, v1_y = '0;
	logic [CB-1:0] v2_x = '0, v2_y = '0, pix_x = '0, pix_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [WEIGHT_BITS-1:0] weight0, weight1, weight2;
	logic degenerate;

	int unsigned pend_cnt, fail_cnt;
	bit calm_phase = 1'b0;
	bit hold_go = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	barycentric_weights_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.v0_x(v0_x), .v0_y(v0_y), .v1_x(v1_x), .v1_y(v1_y),
		.v2_x(v2_x), .v2_y(v2_y), .pix_x(pix_x), .pix_y(pix_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.weight0(weight0), .weight1(weight1), .weight2(weight2),
		.degenerate(degenerate)
	);

	bw_weight_checker #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.v0_x(v0_x), .v0_y(v0_y), .v1_x(v1_x), .v1_y(v1_y),
		.v2_x(v2_x), .v2_y(v2_y), .pix_x(pix_x), .pix_y(pix_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.weight0(weight0), .weight1(weight1), .weight2(weight2),
		.degenerate(degenerate),
		.pend_cnt(pend_cnt), .fail_cnt(fail_cnt)
	);

	task automatic offer(input int unsigned a0, a1, a2, a3, a4, a5, a6, a7);
		@(negedge clk);
		while (!calm_phase && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		v0_x <= CB'(a0); v0_y <= CB'(a1); v1_x <= CB'(a2); v1_y <= CB'(a3);
		v2_x <= CB'(a4); v2_y <= CB'(a5); pix_x <= CB'(a6); pix_y <= CB'(a7);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// mix: full random, collinear, slim (near-collinear), windowed triangles
	task automatic offer_random();
		int unsigned kind, dx, dy, ka, kb, sz, bx, by;
		int unsigned c[8];
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			foreach (c[k]) c[k] = $urandom_range(0, CMAX);
		end else if (kind < 40) begin
			dx = $urandom_range(0, 15);
			dy = $urandom_range(0, 15);
			ka = $urandom_range(0, 200);
			kb = $urandom_range(0, 200);
			c[0] = $urandom_range(0, 1000);
			c[1] = $urandom_range(0, 1000);
			c[2] = c[0] + ka * dx;
			c[3] = c[1] + ka * dy;
			c[4] = c[0] + kb * dx;
			c[5] = c[1] + kb * dy;
			if (kind >= 25) begin
				if ($urandom_range(0, 1))
					c[4] = c[4] + 1;
				else
					c[5] = c[5] + 1;
			end
			if ($urandom_range(0, 1)) begin
				c[0] = CMAX - c[0]; c[2] = CMAX - c[2]; c[4] = CMAX - c[4];
			end
			if ($urandom_range(0, 1)) begin
				c[1] = CMAX - c[1]; c[3] = CMAX - c[3]; c[5] = CMAX - c[5];
			end
			c[6] = $urandom_range(0, CMAX);
			c[7] = $urandom_range(0, CMAX);
		end else begin
			case ($urandom_range(0, 2))
				0: sz = 15;
				1: sz = 255;
				default: sz = CMAX;
			endcase
			bx = $urandom_range(0, CMAX - sz);
			by = $urandom_range(0, CMAX - sz);
			for (int k = 0; k < 8; k += 2) begin
				c[k]   = bx + $urandom_range(0, sz);
				c[k+1] = by + $urandom_range(0, sz);
			end
		end
		offer(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endtask

	initial begin : rx
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				out_ready <= 1'b0;
				hold_done = 1'b1;
				repeat (300) @(negedge clk);
			end else begin
				out_ready <= calm_phase || ($urandom_range(0, 99) >= 8);
			end
		end
	end

	initial begin : stim
		int unsigned i;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		offer(0, 0, 0, 0, 0, 0, 0, 0);
		offer(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
		offer(0, 0, 3, 0, 0, 3, 1, 1);
		offer(0, 0, 3, 0, 0, 3, 7, 1);
		offer(100, 200, 900, 250, 400, 1000, 100, 200);
		offer(100, 200, 900, 250, 400, 1000, 900, 250);
		offer(100, 200, 900, 250, 400, 1000, 400, 1000);
		offer(100, 200, 400, 1000, 900, 250, 500, 500);
		offer(0, 0, 10, 20, 30, 60, 5, 5);
		offer(50, 50, 50, 50, 900, 10, 60, 60);
		// slim triangles, far pixel: clamps at both ends
		offer(0, 0, 4095, 4094, 4094, 4093, 0, 4095);
		offer(0, 0, 4095, 4094, 4094, 4093, 4095, 0);
		offer(0, 4095, 4095, 0, 0, 0, 4095, 4095);
		offer(4095, 0, 0, 4095, 4095, 4095, 0, 0);
		offer('hAAA, 'h555, 'h555, 'hAAA, 'hFFF, 'h000, 'hAAA, 'h555);
		offer('h555, 'hAAA, 'hAAA, 'h555, 'h000, 'hFFF, 'h555, 'hAAA);
		offer(0, 0, 1, 0, 0, 1, 4095, 4095);
		offer(4095, 4095, 4094, 4095, 4095, 4094, 0, 0);
		offer(0, 0, 3000, 0, 0, 3000, 1000, 1000);

		for (i = 0; i < 1530; i++) begin
			calm_phase = (i >= 600) && (i < 900);
			if (i == 200)
				hold_go = 1'b1;
			offer_random();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		wait (pend_cnt == 0);
		repeat (60) @(posedge clk);
		if (fail_cnt == 0 && pend_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#(12 * 200000);
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/bw_pkg.sv
rtl/core/bw_front.sv
rtl/core/bw_queue.sv
rtl/core/bw_div.sv
rtl/core/barycentric_weights_top.sv
tb/bw_weight_checker.sv
tb/tb_barycentric_weights_top.sv
